@@ rtl/vwd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwd_pkg
// Shared types and constants of the vignetting / white balance / dither block.
// ----------------------------------------------------------------------------
package vwd_pkg;

  // position counter width, width and height use their low DimBits bits
  localparam int DimBits = 16;

  // configuration port
  localparam int CfgDataW = 60;
  localparam int CfgIdxW  = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgContrastConst = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgContrastX     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgContrastY     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgChannelGains  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgChannelOffs   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgGeometry      = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgXStep         = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgYStep         = 3'd7;

  // register reset values
  localparam logic [19:0] ContrastConstRst = 20'h10000;
  localparam logic [59:0] ChannelGainsRst  = 60'h010000100001_0000;
  localparam logic [24:0] StepRst          = 25'h1000000;

  // offset saturation, +-2.0 in Q.24
  localparam int OfsLimit = 33554432;

  // residual saturation, signed Q8.16
  localparam int ResMax = 8388607;
  localparam int ResMin = -8388608;

  // depth of the queue between front and back
  localparam int QueueDepth = 2;

  // decoded configuration
  typedef struct packed {
    logic signed [19:0]   contrast_const;
    logic [39:0]          x_terms;
    logic [39:0]          y_terms;
    logic [59:0]          gains;
    logic [47:0]          offsets;
    logic [DimBits-1:0]   width;
    logic [DimBits-1:0]   height;
    logic                 gray;
    logic [24:0]          x_step;
    logic [24:0]          y_step;
  } cfg_t;

  // one pixel with its position, as classified by the front
  typedef struct packed {
    logic [7:0]           pix_b;
    logic [7:0]           pix_g;
    logic [7:0]           pix_r;
    logic [DimBits-1:0]   col;
    logic [DimBits-1:0]   row;
    logic                 frame_start;
    logic                 last;
  } item_t;

endpackage

@@ rtl/vignette_whitebalance_dither.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vignette_whitebalance_dither
// Vignetting and white balance correction with error-diffusion dithering.
// ----------------------------------------------------------------------------
// Each pixel word leaves the two-word queue and then passes through seven
// steps of the back sequencer (offset multiply, square term, linear term,
// gain sum, sample times gain, channel gain, truncate and dither), which
// works on one word at a time. The front keeps accepting words, with
// position and frame end already worked out, until the queue holds two. A
// word with frame_start set restarts the position at 0,0 and clears the
// three residuals. Write the configuration only while no word is in flight.
module vignette_whitebalance_dither (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [vwd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [vwd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   pix_b_i,
  input  logic [7:0]                   pix_g_i,
  input  logic [7:0]                   pix_r_i,
  input  logic                         frame_start_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   out_b_o,
  output logic [7:0]                   out_g_o,
  output logic [7:0]                   out_r_o,
  output logic                         frame_last_o
);

  localparam int DW = vwd_pkg::DimBits;

  vwd_pkg::cfg_t  cfg_q;
  logic           push;
  vwd_pkg::item_t push_item;
  logic           q_full;
  logic           q_pop;
  vwd_pkg::item_t q_item;
  logic           q_valid;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.contrast_const <= vwd_pkg::ContrastConstRst;
      cfg_q.x_terms        <= '0;
      cfg_q.y_terms        <= '0;
      cfg_q.gains          <= vwd_pkg::ChannelGainsRst;
      cfg_q.offsets        <= '0;
      cfg_q.width          <= DW'(1);
      cfg_q.height         <= DW'(1);
      cfg_q.gray           <= 1'b0;
      cfg_q.x_step         <= vwd_pkg::StepRst;
      cfg_q.y_step         <= vwd_pkg::StepRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vwd_pkg::CfgContrastConst: cfg_q.contrast_const <= cfg_data_i[19:0];
        vwd_pkg::CfgContrastX:     cfg_q.x_terms        <= cfg_data_i[39:0];
        vwd_pkg::CfgContrastY:     cfg_q.y_terms        <= cfg_data_i[39:0];
        vwd_pkg::CfgChannelGains:  cfg_q.gains          <= cfg_data_i[59:0];
        vwd_pkg::CfgChannelOffs:   cfg_q.offsets        <= cfg_data_i[47:0];
        vwd_pkg::CfgGeometry: begin
          cfg_q.width  <= cfg_data_i[DW-1:0];
          cfg_q.height <= cfg_data_i[16 +: DW];
          cfg_q.gray   <= cfg_data_i[32];
        end
        vwd_pkg::CfgXStep:         cfg_q.x_step         <= cfg_data_i[24:0];
        vwd_pkg::CfgYStep:         cfg_q.y_step         <= cfg_data_i[24:0];
        default: ;
      endcase
    end
  end

  // position tracking front
  vwd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .width_i       (cfg_q.width),
    .height_i      (cfg_q.height),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pix_b_i       (pix_b_i),
    .pix_g_i       (pix_g_i),
    .pix_r_i       (pix_r_i),
    .frame_start_i (frame_start_i),
    .push_o        (push),
    .push_item_o   (push_item),
    .full_i        (q_full)
  );

  // word queue
  vwd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_item_o  (q_item),
    .valid_o     (q_valid)
  );

  // arithmetic back
  vwd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_b_o      (out_b_o),
    .out_g_o      (out_g_o),
    .out_r_o      (out_r_o),
    .frame_last_o (frame_last_o)
  );

endmodule

@@ rtl/vwd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwd_queue
// Short word queue between the position front and the arithmetic back.
// ----------------------------------------------------------------------------
module vwd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vwd_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output vwd_pkg::item_t pop_item_o,
  output logic           valid_o
);

  localparam int PtrW = (vwd_pkg::QueueDepth > 1) ? $clog2(vwd_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(vwd_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(vwd_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(vwd_pkg::QueueDepth);

  vwd_pkg::item_t      entry_q [vwd_pkg::QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o     = (count_q == CntFull);
  assign valid_o    = (count_q != '0);
  assign pop_item_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ rtl/vwd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwd_front
// Accepts raster pixels, tracks column and row, flags the last pixel of a
// frame and pushes each word with its position into the queue.
// ----------------------------------------------------------------------------
module vwd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [vwd_pkg::DimBits-1:0] width_i,
  input  logic [vwd_pkg::DimBits-1:0] height_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  pix_b_i,
  input  logic [7:0]                  pix_g_i,
  input  logic [7:0]                  pix_r_i,
  input  logic                        frame_start_i,
  output logic                        push_o,
  output vwd_pkg::item_t              push_item_o,
  input  logic                        full_i
);

  localparam int DW = vwd_pkg::DimBits;

  logic [DW-1:0] col_q, col_d;
  logic [DW-1:0] row_q, row_d;
  logic [DW-1:0] col_base, row_base;
  logic [DW:0]   col_inc, row_inc;
  logic          row_end, last;
  logic          accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  // frame start restarts the position before this word
  assign col_base = frame_start_i ? '0 : col_q;
  assign row_base = frame_start_i ? '0 : row_q;
  assign col_inc  = {1'b0, col_base} + 1'b1;
  assign row_inc  = {1'b0, row_base} + 1'b1;
  assign row_end  = (col_inc >= {1'b0, width_i});
  assign last     = row_end && (row_inc >= {1'b0, height_i});

  // next position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = last ? '0 : row_inc[DW-1:0];
      end else begin
        col_d = col_inc[DW-1:0];
        row_d = row_base;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // queue word
  always_comb begin
    push_item_o.pix_b       = pix_b_i;
    push_item_o.pix_g       = pix_g_i;
    push_item_o.pix_r       = pix_r_i;
    push_item_o.col         = col_base;
    push_item_o.row         = row_base;
    push_item_o.frame_start = frame_start_i;
    push_item_o.last        = last;
  end

endmodule

@@ rtl/vwd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwd_back
// Arithmetic sequencer: position offsets, gain polynomial, channel gain and
// offset (none if gray), then truncation with error diffusion into out_q.
// ----------------------------------------------------------------------------
module vwd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vwd_pkg::cfg_t  cfg_i,
  input  logic           q_valid_i,
  input  vwd_pkg::item_t q_item_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_b_o,
  output logic [7:0]     out_g_o,
  output logic [7:0]     out_r_o,
  output logic           frame_last_o
);

  localparam int DW    = vwd_pkg::DimBits;
  localparam int OfsDW = DW + 2;           // 2*pos - dim
  localparam int ProdW = OfsDW + 26;       // times unsigned step
  localparam int XdW   = 27;               // offset, Q.24 within +-2.0
  localparam int SqW   = 20 + XdW;
  localparam int InW   = 24;
  localparam int LinW  = InW + XdW;
  localparam int CW    = 25;               // position gain, Q.16
  localparam int VcW   = 9 + CW;
  localparam int VcgW  = VcW + 20;
  localparam int ValW  = 40;
  localparam int ResW  = 24;

  localparam logic signed [ProdW-1:0] OfsHi  = ProdW'(vwd_pkg::OfsLimit);
  localparam logic signed [ProdW-1:0] OfsLo  = -OfsHi;
  localparam logic signed [ValW-1:0]  ResHi  = ValW'(vwd_pkg::ResMax);
  localparam logic signed [ValW-1:0]  ResLo  = ValW'(vwd_pkg::ResMin);
  localparam logic signed [ValW-1:0]  SatSub = ValW'(255 * 65536);

  // sequencer codes
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StOfs  = 3'd1;
  localparam logic [2:0] StSq   = 3'd2;
  localparam logic [2:0] StLin  = 3'd3;
  localparam logic [2:0] StSum  = 3'd4;
  localparam logic [2:0] StVc   = 3'd5;
  localparam logic [2:0] StGain = 3'd6;
  localparam logic [2:0] StFin  = 3'd7;

  logic [2:0]               state_q, state_d;
  vwd_pkg::item_t           item_q;
  logic signed [ProdW-1:0]  prodx_q, prody_q;
  logic signed [XdW-1:0]    xd_q, yd_q;
  logic signed [SqW-1:0]    sqx_q, sqy_q;
  logic signed [LinW-1:0]   linx_q, liny_q;
  logic signed [CW-1:0]     c_q;
  logic signed [VcW-1:0]    vc_q [3];
  logic signed [VcgW-1:0]   vcg_q [3];
  logic signed [ResW-1:0]   res_q [3];
  logic                     out_valid_q;
  logic [7:0]               out_q [3];
  logic                     last_q;

  logic signed [OfsDW-1:0]  dx, dy;
  logic signed [ProdW-1:0]  halfx, halfy;
  logic signed [XdW-1:0]    xd, yd;
  logic signed [SqW-1:0]    sqx_sh, sqy_sh;
  logic signed [InW-1:0]    innerx, innery;
  logic signed [LinW-1:0]   linx_sh, liny_sh;
  logic [7:0]               pix [3];
  logic signed [ResW-1:0]   res_base [3];
  logic signed [ValW-1:0]   val [3];
  logic signed [ValW-1:0]   sum [3];
  logic signed [ValW-1:0]   rem [3];
  logic [7:0]               fin_out [3];
  logic signed [ResW-1:0]   fin_res [3];
  logic                     fin_go;

  assign q_pop_o = (state_q == StIdle) && q_valid_i;
  assign fin_go  = (state_q == StFin) && (!out_valid_q || !out_stall_i);

  assign pix[0] = item_q.pix_b;
  assign pix[1] = item_q.pix_g;
  assign pix[2] = item_q.pix_r;

  // doubled offsets from the centre
  assign dx = $signed({1'b0, item_q.col, 1'b0}) - $signed({2'b00, cfg_i.width});
  assign dy = $signed({1'b0, item_q.row, 1'b0}) - $signed({2'b00, cfg_i.height});

  // halve rounding down, saturate to +-2.0
  assign halfx = prodx_q >>> 1;
  assign halfy = prody_q >>> 1;
  assign xd = (halfx > OfsHi) ? XdW'(OfsHi) : ((halfx < OfsLo) ? XdW'(OfsLo) : XdW'(halfx));
  assign yd = (halfy > OfsHi) ? XdW'(OfsHi) : ((halfy < OfsLo) ? XdW'(OfsLo) : XdW'(halfy));

  // linear coefficient plus square term
  assign sqx_sh = sqx_q >>> 24;
  assign sqy_sh = sqy_q >>> 24;
  assign innerx = InW'($signed(cfg_i.x_terms[19:0])) + InW'(sqx_sh);
  assign innery = InW'($signed(cfg_i.y_terms[19:0])) + InW'(sqy_sh);

  assign linx_sh = linx_q >>> 24;
  assign liny_sh = liny_q >>> 24;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (q_valid_i) state_d = StOfs;
      StOfs:  state_d = StSq;
      StSq:   state_d = StLin;
      StLin:  state_d = StSum;
      StSum:  state_d = StVc;
      StVc:   state_d = StGain;
      StGain: state_d = StFin;
      StFin:  if (fin_go) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // arithmetic steps, all multiplies but the gain sum
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
    end
    if (state_q == StOfs) begin
      prodx_q <= dx * $signed({1'b0, cfg_i.x_step});
      prody_q <= dy * $signed({1'b0, cfg_i.y_step});
    end
    if (state_q == StSq) begin
      xd_q  <= xd;
      yd_q  <= yd;
      sqx_q <= $signed(cfg_i.x_terms[39:20]) * xd;
      sqy_q <= $signed(cfg_i.y_terms[39:20]) * yd;
    end
    if (state_q == StLin) begin
      linx_q <= innerx * xd_q;
      liny_q <= innery * yd_q;
    end
    if (state_q == StSum) begin
      c_q <= CW'(cfg_i.contrast_const) + CW'(linx_sh) + CW'(liny_sh);
    end
    for (int k = 0; k < 3; k++) begin
      if (state_q == StVc) begin
        vc_q[k] <= $signed({1'b0, pix[k]}) * c_q;
      end
      if (state_q == StGain) begin
        vcg_q[k] <= vc_q[k] * $signed(cfg_i.gains[20*k +: 20]);
      end
    end
  end

  // truncation toward zero with clamp and residual carry
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      res_base[k] = item_q.frame_start ? '0 : res_q[k];
      if (cfg_i.gray) begin
        val[k] = ValW'(vc_q[0]);
      end else begin
        val[k] = ValW'(vcg_q[k] >>> 16)
               + (ValW'($signed(cfg_i.offsets[16*k +: 16])) <<< 10);
      end
      sum[k] = val[k] + ValW'(res_base[k]);
      if (sum[k] < 0) begin
        fin_out[k] = 8'd0;
        rem[k]     = sum[k];
      end else if (sum[k][ValW-1:16] > (ValW-16)'(255)) begin
        fin_out[k] = 8'd255;
        rem[k]     = sum[k] - SatSub;
      end else begin
        fin_out[k] = sum[k][23:16];
        rem[k]     = ValW'({sum[k][15:0]});
      end
      if (rem[k] > ResHi) begin
        fin_res[k] = ResW'(ResHi);
      end else if (rem[k] < ResLo) begin
        fin_res[k] = ResW'(ResLo);
      end else begin
        fin_res[k] = ResW'(rem[k]);
      end
      // gray mode drives channels 1 and 2 to zero and keeps their residuals
      if (cfg_i.gray && (k != 0)) begin
        fin_out[k] = 8'd0;
        fin_res[k] = res_base[k];
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        res_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (fin_go) begin
        out_valid_q <= 1'b1;
        for (int k = 0; k < 3; k++) begin
          res_q[k] <= fin_res[k];
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      for (int k = 0; k < 3; k++) begin
        out_q[k] <= fin_out[k];
      end
      last_q <= item_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_b_o      = out_q[0];
  assign out_g_o      = out_q[1];
  assign out_r_o      = out_q[2];
  assign frame_last_o = last_q;

endmodule
